### hdl/lkvc_pkg.sv
// Shared constants and controller/datapath interface types for the LRU key/value cache.
package lkvc_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;
   localparam int CAPACITY_W = 5;
   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;
   localparam int WORD_W = 32;
   localparam logic [WORD_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   localparam logic CMD_SET = 1'b0;
   localparam logic CMD_GET = 1'b1;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic pass_upd;
      logic decide;
   } ctl_cmd_type;

   typedef struct packed {
      logic upd_needed;
   } ctl_sts_type;

endpackage

### hdl/lkvc_ctrl.sv
// Sequencer for the lookup scan and the recency update pass.
module lkvc_ctrl #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEFAULT,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   output lkvc_pkg::ctl_cmd_type     cmd,
   output logic [IDX_W-1:0]          rd_idx,
   input  lkvc_pkg::ctl_sts_type     sts
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ENTRIES);

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != CNT_LAST) begin
               cmd.rd_en = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            cnt_in     = '0;
            state_in   = sts.upd_needed ? ST_UPDATE : ST_IDLE;
         end
         ST_UPDATE: begin
            if (cnt_ff != CNT_LAST) begin
               cmd.rd_en    = 1'b1;
               cmd.pass_upd = 1'b1;
               cnt_in       = cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign rd_idx = cnt_ff[IDX_W-1:0];

endmodule

### hdl/lkvc_dpath.sv
// Entry store, key match scan, LRU bookkeeping and result register.
module lkvc_dpath #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEFAULT,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int RANK_W = IDX_W,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lkvc_pkg::ctl_cmd_type                cmd,
   input  logic [IDX_W-1:0]                     rd_idx,
   output lkvc_pkg::ctl_sts_type                sts,
   input  logic                                 req_cmd,
   input  logic signed [lkvc_pkg::WORD_W-1:0]   req_key,
   input  logic signed [lkvc_pkg::WORD_W-1:0]   req_value,
   input  logic                                 csr_valid,
   input  logic [lkvc_pkg::CAPACITY_W-1:0]      csr_data,
   output logic                                 rsp_strobe,
   output logic                                 rsp_hit,
   output logic signed [lkvc_pkg::WORD_W-1:0]   rsp_read_value
);

   localparam int W = lkvc_pkg::WORD_W;

   logic [W-1:0]      key_mem_ff  [MAX_ENTRIES];
   logic [W-1:0]      val_mem_ff  [MAX_ENTRIES];
   logic [RANK_W-1:0] rank_mem_ff [MAX_ENTRIES];

   logic [W-1:0]      rd_key_ff, rd_val_ff;
   logic [RANK_W-1:0] rd_rank_ff;

   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [lkvc_pkg::CAPACITY_W-1:0] cap_ff;

   logic              eval_vld_ff, eval_upd_ff;
   logic [IDX_W-1:0]  eval_idx_ff;

   logic              op_ff, op_in;
   logic [W-1:0]      key_ff, key_in, value_ff, value_in;
   logic              match_ff, match_in, free_ff, free_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in, free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]  lru_idx_ff, lru_idx_in;
   logic [RANK_W-1:0] match_rank_ff, match_rank_in;
   logic [W-1:0]      match_val_ff, match_val_in;
   logic [IDX_W-1:0]  tgt_idx_ff, tgt_idx_in;
   logic [RANK_W-1:0] promo_rank_ff, promo_rank_in;

   logic              rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic [W-1:0]      rsp_val_ff, rsp_val_in;

   logic              wr_en;
   logic [W-1:0]      wr_key, wr_val;
   logic [RANK_W-1:0] wr_rank;
   logic              room;
   logic              eval_valid;
   logic [RANK_W-1:0] lru_rank;

   assign eval_valid = valid_ff[eval_idx_ff];
   assign lru_rank   = RANK_W'(fill_ff - CNT_W'(1));
   assign room = (32'(fill_ff) < 32'(MAX_ENTRIES)) &&
                 (32'(fill_ff) < ((cap_ff == '0) ? 32'd1 : 32'(cap_ff)));
   assign sts.upd_needed = match_ff || (op_ff == lkvc_pkg::CMD_SET);

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      match_rank_in = match_rank_ff;
      match_val_in  = match_val_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      lru_idx_in    = lru_idx_ff;
      tgt_idx_in    = tgt_idx_ff;
      promo_rank_in = promo_rank_ff;
      valid_in      = valid_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_val_in    = rsp_val_ff;
      wr_en         = 1'b0;
      wr_key        = rd_key_ff;
      wr_val        = rd_val_ff;
      wr_rank       = rd_rank_ff;

      if (cmd.load) begin
         op_in    = req_cmd;
         key_in   = req_key;
         value_in = req_value;
         match_in = 1'b0;
         free_in  = 1'b0;
      end

      if (eval_vld_ff && !eval_upd_ff) begin
         if (eval_valid && (rd_key_ff == key_ff) && !match_ff) begin
            match_in      = 1'b1;
            match_idx_in  = eval_idx_ff;
            match_rank_in = rd_rank_ff;
            match_val_in  = rd_val_ff;
         end
         if (!eval_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = eval_idx_ff;
         end
         if (eval_valid && (rd_rank_ff == lru_rank)) begin
            lru_idx_in = eval_idx_ff;
         end
      end

      if (cmd.decide) begin
         if (op_ff == lkvc_pkg::CMD_GET) begin
            rsp_valid_in = 1'b1;
            rsp_hit_in   = match_ff;
            rsp_val_in   = match_ff ? match_val_ff : lkvc_pkg::MISS_VALUE;
         end
         priority if (match_ff) begin
            tgt_idx_in    = match_idx_ff;
            promo_rank_in = match_rank_ff;
         end else if (room) begin
            tgt_idx_in            = free_idx_ff;
            promo_rank_in         = RANK_W'(fill_ff);
            valid_in[free_idx_ff] = (op_ff == lkvc_pkg::CMD_SET) ? 1'b1 : valid_ff[free_idx_ff];
            fill_in = (op_ff == lkvc_pkg::CMD_SET) ? fill_ff + CNT_W'(1) : fill_ff;
         end else begin
            tgt_idx_in    = lru_idx_ff;
            promo_rank_in = lru_rank;
         end
      end

      if (eval_vld_ff && eval_upd_ff) begin
         priority if (eval_idx_ff == tgt_idx_ff) begin
            wr_en   = 1'b1;
            wr_key  = key_ff;
            wr_val  = (op_ff == lkvc_pkg::CMD_GET) ? rd_val_ff : value_ff;
            wr_rank = '0;
         end else if (eval_valid && (rd_rank_ff < promo_rank_ff)) begin
            wr_en   = 1'b1;
            wr_rank = rd_rank_ff + RANK_W'(1);
         end else begin
            wr_en = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[eval_idx_ff]  <= wr_key;
         val_mem_ff[eval_idx_ff]  <= wr_val;
         rank_mem_ff[eval_idx_ff] <= wr_rank;
      end
      if (cmd.rd_en) begin
         rd_key_ff  <= key_mem_ff[rd_idx];
         rd_val_ff  <= val_mem_ff[rd_idx];
         rd_rank_ff <= rank_mem_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fill_ff      <= '0;
         cap_ff       <= lkvc_pkg::CAPACITY_RESET;
         eval_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         eval_vld_ff  <= cmd.rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      eval_upd_ff   <= cmd.pass_upd;
      eval_idx_ff   <= rd_idx;
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      match_ff      <= match_in;
      match_idx_ff  <= match_idx_in;
      match_rank_ff <= match_rank_in;
      match_val_ff  <= match_val_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      lru_idx_ff    <= lru_idx_in;
      tgt_idx_ff    <= tgt_idx_in;
      promo_rank_ff <= promo_rank_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_val_ff    <= rsp_val_in;
   end

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_val_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result word held longer than one cycle");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(MAX_ENTRIES))
      else $error("fill count above store depth");

   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(fill_ff))
      else $error("fill count disagrees with valid marks");

endmodule

### hdl/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
//
//   channel   direction  handshake             word
//   req_      in         start & !busy         req_cmd, req_key, req_value
//   rsp_      out        rsp_strobe (1 cycle)  rsp_hit, rsp_read_value
//   csr_      in         csr_valid & csr_ready csr_data (capacity)
//
// Each request scans all MAX_ENTRIES entries through one memory read port:
// busy stays high through the lookup scan and the decide step for a get miss, and through
// the recency update pass as well otherwise; both passes use the same port.
// A get result is registered from the decide step, one cycle wide; the receiver cannot stall.
// Synchronous reset clears valid marks and fill count, reloads capacity; no clearing pass.
// csr_ready is always high.
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEFAULT,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_cmd,
   input  logic signed [lkvc_pkg::WORD_W-1:0]   req_key,
   input  logic signed [lkvc_pkg::WORD_W-1:0]   req_value,
   output logic                                 rsp_strobe,
   output logic                                 rsp_hit,
   output logic signed [lkvc_pkg::WORD_W-1:0]   rsp_read_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lkvc_pkg::CAPACITY_W-1:0]      csr_data
);

   lkvc_pkg::ctl_cmd_type cmd;
   lkvc_pkg::ctl_sts_type sts;
   logic [IDX_W-1:0]      rd_idx;

   assign csr_ready = 1'b1;

   lkvc_ctrl #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .rd_idx (rd_idx),
      .sts    (sts)
   );

   lkvc_dpath #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .rd_idx         (rd_idx),
      .sts            (sts),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_value      (req_value),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value)
   );

endmodule
